// ----- design/rcu_pkg.sv -----
// ---------------------------------------------------------------------------
// Radix-90 coefficient unpacker package
// Shared widths, constants, codes and beat types of the unpacker.
// ---------------------------------------------------------------------------
package rcu_pkg;

   localparam int unsigned PACKED_WORDS = 104;
   localparam int unsigned SLOT_W       = 7;
   localparam int unsigned WORD_W       = 64;
   localparam int unsigned RADIX_W      = 52;
   localparam int unsigned DIGIT_W      = 7;
   localparam int unsigned INDEX_W      = 10;
   localparam int unsigned CHUNK_W      = 13;
   localparam int unsigned DIVIDEND_W   = DIGIT_W + CHUNK_W;
   localparam int unsigned CHUNKS       = RADIX_W / CHUNK_W;
   localparam int unsigned DIGITS       = 8;
   localparam int unsigned RECIP_W      = 16;
   localparam int unsigned RECIP_SHIFT  = 22;

   localparam logic [DIGIT_W-1:0] RADIX = 7'd90;
   localparam logic [RECIP_W-1:0] RECIP = 16'd46603;

   localparam logic [SLOT_W-1:0] SLOT_NIBBLE_LOW  = 7'd64;
   localparam logic [SLOT_W-1:0] SLOT_NIBBLE_HIGH = 7'd101;
   localparam logic [SLOT_W-1:0] SLOT_TAIL_BASE   = 7'd101;
   localparam logic [SLOT_W-1:0] SLOT_HIGH_126    = 7'd102;
   localparam logic [SLOT_W-1:0] SLOT_HIGH_127    = 7'd103;

   localparam logic [SLOT_W-1:0] WORD_TAIL = 7'd125;
   localparam logic [SLOT_W-1:0] WORD_126  = 7'd126;
   localparam logic [SLOT_W-1:0] WORD_127  = 7'd127;

   localparam logic OP_STORE  = 1'b0;
   localparam logic OP_UNPACK = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_GATHER,
      ST_DIGIT
   } state_type;

   typedef enum logic [1:0] {
      KIND_HIGH,
      KIND_SPLIT,
      KIND_TAIL
   } word_kind_type;

   typedef struct packed {
      logic              operation;
      logic [SLOT_W-1:0] word_index;
      logic [WORD_W-1:0] packed_word;
   } req_type;

   typedef struct packed {
      logic [DIGIT_W-1:0] coefficient;
      logic [INDEX_W-1:0] coeff_index;
      logic               last;
   } rsp_type;

   typedef struct packed {
      logic              wr_en;
      logic              rd_en;
      logic [SLOT_W-1:0] addr;
      logic [WORD_W-1:0] data;
   } store_cmd_type;

endpackage

// ----- design/radix90_coeff_unpacker.sv -----
// ---------------------------------------------------------------------------
// Radix-90 coefficient unpacker
// A store beat (operation 0) writes a 64-bit packed word into slot
// word_index; slots 104 to 127 are ignored. It gives no result. An unpack
// beat (operation 1) rebuilds radix word word_index from one to five
// stored packed words and returns its eight base-90 digits, least
// significant first, on rsp_data with coeff_index 8*word_index + n.
// A beat is taken when start is high and busy is low. Each digit beat is
// shown for one cycle with rsp_valid high; the receiver cannot stall it.
// The words are read from the single-port store one per cycle, then each
// digit takes four passes through the divide-by-90 step, one 13-bit chunk
// per cycle. The block stays busy, and takes no new beat, until the last
// digit of an unpack is shown; a store does not make the block busy.
// Reset returns the block to idle; the store contents are undefined until
// written and must not be read before.
// ---------------------------------------------------------------------------
module radix90_coeff_unpacker
   import rcu_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   state_type            state_ff, state_in;
   logic [SLOT_W-1:0]    w_ff, w_in;
   logic [RADIX_W-1:0]   x_ff, x_in;
   logic [2:0]           step_ff, step_in;
   logic                 pend_ff, pend_in;
   logic [2:0]           pend_step_ff, pend_step_in;
   logic [DIGIT_W-1:0]   rem_ff, rem_in;
   logic [1:0]           chunk_ff, chunk_in;
   logic [2:0]           digit_ff, digit_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_ff, rsp_in;

   store_cmd_type        cmd;
   logic [WORD_W-1:0]    rd_data;

   logic [14:0]          g_prod;
   logic [4:0]           grp;
   logic [SLOT_W-1:0]    k_full;
   logic [2:0]           k;
   logic [SLOT_W-1:0]    base;
   word_kind_type        kind;
   logic [2:0]           last_step;
   logic [SLOT_W-1:0]    rd_addr;
   logic [5:0]           nib_shift;
   logic [3:0]           nibble;
   logic [5:0]           low_shift;
   logic [RADIX_W-1:0]   field;

   logic [DIVIDEND_W-1:0] div_in;
   logic [CHUNK_W-1:0]    div_q;
   logic [DIGIT_W-1:0]    div_r;

   rcu_store u_store (
      .clock   (clock),
      .cmd     (cmd),
      .rd_data (rd_data)
   );

   rcu_div90 u_div (
      .dividend  (div_in),
      .quotient  (div_q),
      .remainder (div_r)
   );

   always_comb begin
      g_prod = 15'(w_ff) * 15'(205);
      grp    = g_prod[14:10];
      k_full = w_ff - SLOT_W'(grp) * SLOT_W'(5);
      k      = k_full[2:0];
      base   = SLOT_W'({grp, 2'b00}) + SLOT_W'(grp >= 5'd16);

      if (w_ff == WORD_TAIL) begin
         kind      = KIND_TAIL;
         last_step = 3'd2;
      end else if (w_ff == WORD_126 || w_ff == WORD_127 || k != 3'd4) begin
         kind      = KIND_HIGH;
         last_step = 3'd0;
      end else begin
         kind      = KIND_SPLIT;
         last_step = 3'd4;
      end

      unique case (kind)
         KIND_HIGH: begin
            if (w_ff == WORD_126) begin
               rd_addr = SLOT_HIGH_126;
            end else if (w_ff == WORD_127) begin
               rd_addr = SLOT_HIGH_127;
            end else begin
               rd_addr = base + SLOT_W'(k);
            end
         end
         KIND_SPLIT: begin
            if (step_ff == 3'd4) begin
               rd_addr = (grp < 5'd16) ? SLOT_NIBBLE_LOW : SLOT_NIBBLE_HIGH;
            end else begin
               rd_addr = base + SLOT_W'(step_ff);
            end
         end
         KIND_TAIL: begin
            rd_addr = SLOT_TAIL_BASE + SLOT_W'(step_ff);
         end
         default: begin
            rd_addr = base;
         end
      endcase

      nib_shift = 6'd60 - 6'({grp[3:0], 2'b00});
      nibble    = rd_data[nib_shift +: 4];
      low_shift = 6'({pend_step_ff[1:0], 3'b000}) + 6'({pend_step_ff[1:0], 2'b00});

      unique case (kind)
         KIND_HIGH: begin
            field = rd_data[WORD_W-1:12];
         end
         KIND_SPLIT: begin
            if (pend_step_ff == 3'd4) begin
               field = {nibble, 48'd0};
            end else begin
               field = RADIX_W'(rd_data[11:0]) << low_shift;
            end
         end
         KIND_TAIL: begin
            priority if (pend_step_ff == 3'd0) begin
               field = RADIX_W'(rd_data[27:0]);
            end else if (pend_step_ff == 3'd1) begin
               field = RADIX_W'(rd_data[11:0]) << 28;
            end else begin
               field = RADIX_W'(rd_data[11:0]) << 40;
            end
         end
         default: begin
            field = '0;
         end
      endcase

      div_in = {rem_ff, x_ff[RADIX_W-1 -: CHUNK_W]};
   end

   always_comb begin
      state_in     = state_ff;
      w_in         = w_ff;
      x_in         = x_ff;
      step_in      = step_ff;
      pend_in      = 1'b0;
      pend_step_in = pend_step_ff;
      rem_in       = rem_ff;
      chunk_in     = chunk_ff;
      digit_in     = digit_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      cmd.wr_en    = 1'b0;
      cmd.rd_en    = 1'b0;
      cmd.addr     = rd_addr;
      cmd.data     = req_data.packed_word;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (req_data.operation == OP_UNPACK) begin
                  w_in     = req_data.word_index;
                  x_in     = '0;
                  step_in  = 3'd0;
                  state_in = ST_GATHER;
               end else if (req_data.word_index < SLOT_W'(PACKED_WORDS)) begin
                  cmd.wr_en = 1'b1;
                  cmd.addr  = req_data.word_index;
               end
            end
         end
         ST_GATHER: begin
            if (step_ff <= last_step) begin
               cmd.rd_en    = 1'b1;
               pend_in      = 1'b1;
               pend_step_in = step_ff;
               step_in      = step_ff + 3'd1;
            end
            if (pend_ff) begin
               x_in = x_ff | field;
               if (pend_step_ff == last_step) begin
                  state_in = ST_DIGIT;
                  rem_in   = '0;
                  chunk_in = 2'd0;
                  digit_in = 3'd0;
               end
            end
         end
         ST_DIGIT: begin
            x_in     = {x_ff[RADIX_W-CHUNK_W-1:0], div_q};
            rem_in   = div_r;
            chunk_in = chunk_ff + 2'd1;
            if (chunk_ff == 2'(CHUNKS - 1)) begin
               rsp_valid_in       = 1'b1;
               rsp_in.coefficient = div_r;
               rsp_in.coeff_index = {w_ff, digit_ff};
               rsp_in.last        = (digit_ff == 3'(DIGITS - 1));
               rem_in             = '0;
               digit_in           = digit_ff + 3'd1;
               if (digit_ff == 3'(DIGITS - 1)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      w_ff         <= w_in;
      x_ff         <= x_in;
      step_ff      <= step_in;
      pend_step_ff <= pend_step_in;
      rem_ff       <= rem_in;
      chunk_ff     <= chunk_in;
      digit_ff     <= digit_in;
      rsp_ff       <= rsp_in;
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ----- design/rcu_store.sv -----
// ---------------------------------------------------------------------------
// Packed word store
// Single-port synchronous memory of packed words with a registered read.
// ---------------------------------------------------------------------------
module rcu_store
   import rcu_pkg::*;
(
   input  logic              clock,
   input  store_cmd_type     cmd,
   output logic [WORD_W-1:0] rd_data
);

   logic [WORD_W-1:0] mem [PACKED_WORDS];

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[cmd.addr] <= cmd.data;
      end
      if (cmd.rd_en) begin
         rd_data <= mem[cmd.addr];
      end
   end

endmodule

// ----- design/rcu_div90.sv -----
// ---------------------------------------------------------------------------
// Divide-by-90 step
// Divides a remainder joined with one chunk of the radix word by 90, using a
// reciprocal multiply and a single correction.
// ---------------------------------------------------------------------------
module rcu_div90
   import rcu_pkg::*;
(
   input  logic [DIVIDEND_W-1:0] dividend,
   output logic [CHUNK_W-1:0]    quotient,
   output logic [DIGIT_W-1:0]    remainder
);

   localparam int unsigned PROD_W = DIVIDEND_W + RECIP_W;

   logic [PROD_W-1:0]     prod;
   logic [CHUNK_W-1:0]    q_est;
   logic [DIVIDEND_W-1:0] r_est;

   always_comb begin
      prod  = PROD_W'(dividend) * PROD_W'(RECIP);
      q_est = prod[RECIP_SHIFT +: CHUNK_W];
      r_est = dividend - DIVIDEND_W'(q_est) * DIVIDEND_W'(RADIX);
      if (r_est >= DIVIDEND_W'(RADIX)) begin
         quotient  = q_est + CHUNK_W'(1);
         remainder = DIGIT_W'(r_est - DIVIDEND_W'(RADIX));
      end else begin
         quotient  = q_est;
         remainder = r_est[DIGIT_W-1:0];
      end
   end

endmodule

// ----- tb/sv/tb_radix90_coeff_unpacker.sv -----
// ---------------------------------------------------------------------------
// Radix-90 coefficient unpacker testbench
// Drives store and unpack beats through the start/busy handshake and keeps
// its own copy of the packed store. Every accepted unpack is turned into
// eight expected digit beats, and each digit beat from the block is checked
// field by field against the oldest one. A short directed table comes first,
// then random stores, unpacks and whole-group sequences, sent in bursts.
// ---------------------------------------------------------------------------
module tb_radix90_coeff_unpacker;
   import rcu_pkg::*;

   typedef struct packed {
      req_type                          beat;
      logic                             typed;
      logic [DIGITS-1:0][DIGIT_W-1:0]   digits;
   } directed_row_type;

   localparam int unsigned ROWS        = 25;
   localparam int unsigned RANDOM_BEATS = 350;
   localparam logic [WORD_W-1:0] ONES  = '1;

   logic    clock = 1'b0;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_valid;
   rsp_type rsp_data;

   logic [WORD_W-1:0] packed_copy [PACKED_WORDS];
   bit                slot_written [PACKED_WORDS];
   rsp_type           pending_digits [$];
   int unsigned       mismatches = 0;
   int unsigned       burst_left = 0;

   directed_row_type directed_rows [ROWS] = '{
      '{'{OP_STORE,  7'd0,   64'd0},                   1'b0, '0},
      '{'{OP_UNPACK, 7'd0,   64'd0},                   1'b1, '0},
      '{'{OP_STORE,  7'd0,   {52'd89, 12'hFFF}},       1'b0, '0},
      '{'{OP_UNPACK, 7'd0,   ONES},                    1'b1, {{7{7'd0}}, 7'd89}},
      '{'{OP_STORE,  7'd0,   ONES},                    1'b0, '0},
      '{'{OP_UNPACK, 7'd0,   64'd0},                   1'b0, '0},
      '{'{OP_STORE,  7'd1,   ONES},                    1'b0, '0},
      '{'{OP_STORE,  7'd2,   ONES},                    1'b0, '0},
      '{'{OP_STORE,  7'd3,   ONES},                    1'b0, '0},
      '{'{OP_STORE,  7'd64,  ONES},                    1'b0, '0},
      '{'{OP_UNPACK, 7'd4,   64'd0},                   1'b0, '0},
      '{'{OP_UNPACK, 7'd3,   64'd0},                   1'b0, '0},
      '{'{OP_STORE,  7'd104, 64'h5A5A_5A5A_5A5A_5A5A}, 1'b0, '0},
      '{'{OP_STORE,  7'd127, ONES},                    1'b0, '0},
      '{'{OP_STORE,  7'd101, ONES},                    1'b0, '0},
      '{'{OP_STORE,  7'd102, 64'h0123_4567_89AB_CDEF}, 1'b0, '0},
      '{'{OP_STORE,  7'd103, 64'd0},                   1'b0, '0},
      '{'{OP_UNPACK, WORD_TAIL, 64'd0},                1'b0, '0},
      '{'{OP_UNPACK, WORD_126,  ONES},                 1'b0, '0},
      '{'{OP_UNPACK, WORD_127,  64'd0},                1'b1, '0},
      '{'{OP_STORE,  7'd97,  64'hFEDC_BA98_7654_3210}, 1'b0, '0},
      '{'{OP_STORE,  7'd98,  64'h8000_0000_0000_0FFF}, 1'b0, '0},
      '{'{OP_STORE,  7'd99,  64'h0000_0000_0000_1000}, 1'b0, '0},
      '{'{OP_STORE,  7'd100, 64'hFFFF_FFFF_FFFF_F000}, 1'b0, '0},
      '{'{OP_UNPACK, 7'd124, 64'd0},                   1'b0, '0}
   };

   radix90_coeff_unpacker DUT (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   always #5 clock = ~clock;

   function automatic int unsigned group_base(input int unsigned g);
      return (g < 16) ? 4 * g : 65 + 4 * (g - 16);
   endfunction

   function automatic int unsigned nibble_slot(input int unsigned g);
      return (g < 16) ? int'(SLOT_NIBBLE_LOW) : int'(SLOT_NIBBLE_HIGH);
   endfunction

   function automatic bit word_readable(input int unsigned w);
      int unsigned g;
      int unsigned b;
      if (w == WORD_TAIL)
         return slot_written[101] && slot_written[102] && slot_written[103];
      if (w == WORD_126)
         return slot_written[102];
      if (w == WORD_127)
         return slot_written[103];
      g = w / 5;
      b = group_base(g);
      if (w % 5 < 4)
         return slot_written[b + w % 5];
      return slot_written[b] && slot_written[b + 1] && slot_written[b + 2]
         && slot_written[b + 3] && slot_written[nibble_slot(g)];
   endfunction

   function automatic logic [WORD_W-1:0] rebuild_radix_word(input int unsigned w);
      int unsigned       g;
      int unsigned       b;
      int unsigned       j;
      logic [WORD_W-1:0] nib;
      if (w == WORD_TAIL)
         return ((packed_copy[103] & 64'hFFF) << 40) | ((packed_copy[102] & 64'hFFF) << 28)
            | (packed_copy[101] & 64'h0FFF_FFFF);
      if (w == WORD_126)
         return packed_copy[102] >> 12;
      if (w == WORD_127)
         return packed_copy[103] >> 12;
      g = w / 5;
      b = group_base(g);
      j = (g < 16) ? g : g - 16;
      nib = (packed_copy[nibble_slot(g)] >> (60 - 4 * j)) & 64'hF;
      if (w % 5 < 4)
         return packed_copy[b + w % 5] >> 12;
      return (nib << 48) | ((packed_copy[b + 3] & 64'hFFF) << 36)
         | ((packed_copy[b + 2] & 64'hFFF) << 24) | ((packed_copy[b + 1] & 64'hFFF) << 12)
         | (packed_copy[b] & 64'hFFF);
   endfunction

   task automatic unpack_digits(input req_type beat, input logic typed,
                                input logic [DIGITS-1:0][DIGIT_W-1:0] digits);
      logic [WORD_W-1:0] x;
      rsp_type           digit_beat;
      if (beat.operation == OP_STORE) begin
         if (beat.word_index < PACKED_WORDS) begin
            packed_copy[beat.word_index] = beat.packed_word;
            slot_written[beat.word_index] = 1'b1;
         end
      end else begin
         x = rebuild_radix_word(beat.word_index);
         for (int n = 0; n < DIGITS; n++) begin
            digit_beat.coefficient = typed ? digits[n] : DIGIT_W'(x % 64'd90);
            digit_beat.coeff_index = INDEX_W'(beat.word_index * 8 + n);
            digit_beat.last = (n == DIGITS - 1);
            pending_digits.push_back(digit_beat);
            x = x / 64'd90;
         end
      end
   endtask

   task automatic send_beat(input req_type beat, input logic typed,
                            input logic [DIGITS-1:0][DIGIT_W-1:0] digits);
      int unsigned gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 45) : $urandom_range(0, 5);
         repeat (gap) begin
            @(negedge clock);
            start <= 1'b0;
         end
         burst_left = ($urandom_range(0, 5) == 0) ? 30 : $urandom_range(1, 10);
      end
      burst_left--;
      @(negedge clock);
      start <= 1'b1;
      req_data <= beat;
      @(posedge clock);
      while (busy)
         @(posedge clock);
      unpack_digits(beat, typed, digits);
   endtask

   function automatic logic [WORD_W-1:0] random_word();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (pending_digits.size() == 0) begin
            $error("unexpected digit beat: index %0d", rsp_data.coeff_index);
            mismatches++;
         end else begin
            want = pending_digits.pop_front();
            if (rsp_data.coefficient !== want.coefficient) begin
               $error("coefficient: expected %0d, got %0d", want.coefficient,
                      rsp_data.coefficient);
               mismatches++;
            end
            if (rsp_data.coeff_index !== want.coeff_index) begin
               $error("coeff_index: expected %0d, got %0d", want.coeff_index,
                      rsp_data.coeff_index);
               mismatches++;
            end
            if (rsp_data.last !== want.last) begin
               $error("last: expected %0b, got %0b", want.last, rsp_data.last);
               mismatches++;
            end
         end
      end
   end

   initial begin
      #5_000_000;
      $display("simulation failed");
      $finish;
   end

   initial begin
      req_type     beat;
      int unsigned sent;
      int unsigned w;
      int unsigned g;
      int unsigned b;
      bit          found;
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      for (int i = 0; i < PACKED_WORDS; i++)
         slot_written[i] = 1'b0;
      repeat (8) @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_beat(directed_rows[i].beat, directed_rows[i].typed, directed_rows[i].digits);

      sent = 0;
      while (sent < RANDOM_BEATS) begin
         case ($urandom_range(0, 9))
            0, 1, 2: begin
               beat = '{OP_STORE, SLOT_W'($urandom_range(0, 127)), random_word()};
               send_beat(beat, 1'b0, '0);
               if (beat.word_index < PACKED_WORDS)
                  sent++;
            end
            3, 4, 5, 6: begin
               found = 1'b0;
               for (int t = 0; t < 16 && !found; t++) begin
                  w = $urandom_range(0, 127);
                  found = word_readable(w);
               end
               if (found) begin
                  send_beat('{OP_UNPACK, SLOT_W'(w), random_word()}, 1'b0, '0);
                  sent++;
               end
            end
            default: begin
               g = $urandom_range(0, 25);
               if (g == 25) begin
                  for (int s = 101; s <= 103; s++)
                     send_beat('{OP_STORE, SLOT_W'(s), random_word()}, 1'b0, '0);
                  for (int u = WORD_TAIL; u <= WORD_127; u++)
                     send_beat('{OP_UNPACK, SLOT_W'(u), random_word()}, 1'b0, '0);
                  sent += 6;
               end else begin
                  b = group_base(g);
                  for (int s = 0; s < 4; s++)
                     send_beat('{OP_STORE, SLOT_W'(b + s), random_word()}, 1'b0, '0);
                  send_beat('{OP_STORE, SLOT_W'(nibble_slot(g)), random_word()}, 1'b0, '0);
                  for (int u = 0; u < 5; u++)
                     send_beat('{OP_UNPACK, SLOT_W'(5 * g + u), random_word()}, 1'b0, '0);
                  sent += 10;
               end
            end
         endcase
      end

      @(negedge clock);
      start <= 1'b0;
      while (pending_digits.size() != 0)
         @(posedge clock);
      repeat (50) @(posedge clock);
      if (mismatches == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
